// File: rtl/core/pipd_pkg.sv
// Shared types, constants and helper functions for the pending-interrupt controller.
package pipd_pkg;

   localparam int NumWords      = 8;
   localparam int WordWidth     = 32;
   localparam int WordAddrWidth = $clog2(NumWords);
   localparam int LevelWidth    = 5;
   localparam int VectorWidth   = 8;
   localparam int AddrWidth     = 32;

   localparam logic [LevelWidth-1:0] TopLevel    = 5'd31;
   localparam logic [AddrWidth-1:0]  EntryOffset = 32'd4;

   localparam logic OP_RAISE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   typedef struct packed {
      logic [2:0]             pad;
      logic [LevelWidth-1:0]  current_priority;
      logic [VectorWidth-1:0] vector;
   } req_data_type;

   typedef struct packed {
      logic [5:0]             pad;
      logic [AddrWidth-1:0]   entry_address;
      logic                   posted;
      logic [VectorWidth-1:0] dispatched_vector;
      logic                   dispatched;
   } rsp_data_type;

   function automatic logic [4:0] top_bit32(input logic [31:0] x);
      logic [4:0] idx;
      idx = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            idx = 5'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [2:0] top_bit8(input logic [7:0] x);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (x[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic may_dispatch(input logic [LevelWidth-1:0] prio,
                                         input logic [LevelWidth-1:0] cur);
      return (prio == TopLevel) || (prio > cur);
   endfunction

endpackage

// File: rtl/core/priority_interrupt_post_and_dispatch.sv
// Top level of the pending-interrupt controller with its pending-vector memory.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/req_tready tuser: operation; tdata: vector, priority
//   rsp      out        rsp_tvalid/rsp_tready tdata: dispatched, vector, posted, address
//   csr      in         csr_we                csr_wdata: table base
//
// Each item passes a read step, which fetches its pending word from the memory,
// and an update step, which changes and writes it back; the memory's registered read port splits them.
// The result sits in an output register; the next item is taken while it waits,
// and the update step stalls only while a previous result is still held.
// Reset clears the level bits, the word valid bits and the table base at once.
module priority_interrupt_post_and_dispatch
   import pipd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // [0] operation
   input  logic [15:0] req_tdata,   // [7:0] vector, [12:8] current_priority, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] dispatched, [8:1] dispatched_vector,
                                    // [9] posted, [41:10] entry_address, zero fill
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RMW  = 1'b1;

   logic                      state_ff, state_in;
   logic                      op_ff;
   logic [VectorWidth-1:0]    vec_ff;
   logic [LevelWidth-1:0]     cur_ff;
   logic [LevelWidth-1:0]     lvl_ff;
   logic                      lvl_any_ff;
   logic [WordAddrWidth-1:0]  word_ff, word_in;
   logic [WordWidth-1:0]      rd_data_ff;
   logic                      rd_valid_ff;
   logic [NumWords-1:0]       mem_valid_ff;
   logic [WordWidth-1:0]      levels_ff, levels_in;
   logic [AddrWidth-1:0]      base_ff;
   logic                      rsp_valid_ff;
   rsp_data_type              rsp_data_ff, rsp_data_in;
   logic [WordWidth-1:0]      pend_mem [NumWords];

   req_data_type              req_data;
   logic                      accept;
   logic                      fire;
   logic                      wr_en;
   logic [WordWidth-1:0]      wr_data;
   logic [LevelWidth-1:0]     req_top;

   logic [WordWidth-1:0]      cur_word;
   logic [LevelWidth-1:0]     rs_prio;
   logic [7:0]                chk_byte;
   logic [7:0]                new_byte;
   logic [2:0]                chk_off;
   logic [VectorWidth-1:0]    chk_vec;
   logic [WordWidth-1:0]      cleared_word;

   assign req_data   = req_tdata;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == ST_RMW) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_top    = top_bit32(levels_ff);

   always_comb begin
      word_in = (req_tuser[0] == OP_CHECK) ? req_top[4:2] : req_data.vector[7:5];
   end

   always_comb begin
      cur_word     = rd_valid_ff ? rd_data_ff : '0;
      rs_prio      = vec_ff[7:3];
      chk_byte     = cur_word[{lvl_ff[1:0], 3'b000} +: 8];
      chk_off      = top_bit8(chk_byte);
      chk_vec      = {lvl_ff, chk_off};
      cleared_word = cur_word & ~(32'd1 << chk_vec[4:0]);
      new_byte     = cleared_word[{lvl_ff[1:0], 3'b000} +: 8];
      wr_en        = 1'b0;
      wr_data      = cur_word;
      levels_in    = levels_ff;
      rsp_data_in  = '0;
      unique case (op_ff)
         OP_RAISE: begin
            if (vec_ff[7:3] != 5'd0) begin
               if (may_dispatch(rs_prio, cur_ff)) begin
                  rsp_data_in.dispatched        = 1'b1;
                  rsp_data_in.dispatched_vector = vec_ff;
               end else begin
                  wr_en                  = 1'b1;
                  wr_data                = cur_word | (32'd1 << vec_ff[4:0]);
                  levels_in[rs_prio]     = 1'b1;
                  rsp_data_in.posted     = 1'b1;
               end
            end
         end
         OP_CHECK: begin
            if (lvl_any_ff && (chk_byte != 8'd0) && (lvl_ff != 5'd0)
                && may_dispatch(lvl_ff, cur_ff)) begin
               wr_en                         = 1'b1;
               wr_data                       = cleared_word;
               if (new_byte == 8'd0) begin
                  levels_in[lvl_ff] = 1'b0;
               end
               rsp_data_in.dispatched        = 1'b1;
               rsp_data_in.dispatched_vector = chk_vec;
            end
         end
         default: begin
         end
      endcase
      if (rsp_data_in.dispatched) begin
         rsp_data_in.entry_address = base_ff + EntryOffset
                                     + {22'd0, rsp_data_in.dispatched_vector, 2'b00};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RMW;
            end
         end
         ST_RMW: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= pend_mem[word_in];
      end
      if (fire && wr_en) begin
         pend_mem[word_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_tuser[0];
         vec_ff      <= req_data.vector;
         cur_ff      <= req_data.current_priority;
         lvl_ff      <= req_top;
         lvl_any_ff  <= (levels_ff != '0);
         word_ff     <= word_in;
         rd_valid_ff <= mem_valid_ff[word_in];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mem_valid_ff <= '0;
         levels_ff    <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (fire) begin
            levels_ff    <= levels_in;
            rsp_valid_ff <= 1'b1;
            if (wr_en) begin
               mem_valid_ff[word_ff] <= 1'b1;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RMW) && !req_tready)
      else $error("Accepted item did not enter the update step.");

   a_level_zero_never_pending: assert property (@(posedge clock) disable iff (reset)
      !levels_ff[0])
      else $error("Invalid priority level marked pending.");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.dispatched && rsp_data_ff.posted))
      else $error("Result both dispatched and posted.");

   a_held_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("Held result changed before it was taken.");
`endif

endmodule
